// ===== src/xid_pkg.sv =====
// Shared types, constants and opcode classifiers for the 8086 decoder.
// Used by xid_front, xid_queue, xid_back and the top level; no dependencies.
package xid_pkg;

   localparam int QueueDepth = 2;
   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);
   localparam int RspWidth   = 56;

   localparam logic [2:0] DIRECT_RM    = 3'b110;
   localparam logic [1:0] MOD_REGISTER = 2'b11;
   localparam logic [1:0] MOD_NODISP   = 2'b00;
   localparam logic [2:0] ALU_XOR      = 3'b110;

   typedef enum logic [2:0] {
      PH_OPCODE  = 3'd0,
      PH_MODRM   = 3'd1,
      PH_DISP_LO = 3'd2,
      PH_DISP_HI = 3'd3,
      PH_IMM_LO  = 3'd4,
      PH_IMM_HI  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      GRP_MOV   = 3'd0,
      GRP_ALU   = 3'd1,
      GRP_JCC   = 3'd2,
      GRP_LOOP  = 3'd3,
      GRP_UNSUP = 3'd4
   } group_type;

   typedef enum logic [1:0] {
      KIND_REG  = 2'd0,
      KIND_MEM  = 2'd1,
      KIND_IMM  = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   // one gathered instruction, handed from front to back
   typedef struct packed {
      logic        unsup;
      logic [7:0]  opcode;
      logic [7:0]  modrm;
      logic [15:0] disp;
      logic [15:0] imm;
   } entry_type;

   function automatic logic is_alu_rm(input logic [7:0] o);
      return ((o & 8'hC4) == 8'h00) && (o[5:3] != ALU_XOR);
   endfunction

   function automatic logic is_alu_acc(input logic [7:0] o);
      return ((o & 8'hC6) == 8'h04) && (o[5:3] != ALU_XOR);
   endfunction

   function automatic logic is_grp_imm(input logic [7:0] o);
      return (o & 8'hFC) == 8'h80;
   endfunction

   function automatic logic is_mov_rm(input logic [7:0] o);
      return (o & 8'hFC) == 8'h88;
   endfunction

   function automatic logic is_mov_acc(input logic [7:0] o);
      return (o & 8'hFC) == 8'hA0;
   endfunction

   function automatic logic is_mov_imm_reg(input logic [7:0] o);
      return (o & 8'hF0) == 8'hB0;
   endfunction

   function automatic logic is_mov_imm_rm(input logic [7:0] o);
      return (o & 8'hFE) == 8'hC6;
   endfunction

   function automatic logic is_jcc(input logic [7:0] o);
      return (o & 8'hF0) == 8'h70;
   endfunction

   function automatic logic is_loop(input logic [7:0] o);
      return (o & 8'hFC) == 8'hE0;
   endfunction

   function automatic logic needs_modrm(input logic [7:0] o);
      return is_alu_rm(o) || is_grp_imm(o) || is_mov_rm(o) || is_mov_imm_rm(o);
   endfunction

   function automatic logic supported(input logic [7:0] o);
      return needs_modrm(o) || is_alu_acc(o) || is_mov_acc(o) ||
             is_mov_imm_reg(o) || is_jcc(o) || is_loop(o);
   endfunction

   function automatic logic [1:0] imm_len(input logic [7:0] o);
      logic [1:0] len;
      len = 2'd0;
      if (is_grp_imm(o)) begin
         len = (o[1:0] == 2'b01) ? 2'd2 : 2'd1;
      end else if (is_alu_acc(o) || is_mov_imm_rm(o)) begin
         len = o[0] ? 2'd2 : 2'd1;
      end else if (is_mov_imm_reg(o)) begin
         len = o[3] ? 2'd2 : 2'd1;
      end else if (is_jcc(o) || is_loop(o)) begin
         len = 2'd1;
      end
      return len;
   endfunction

   function automatic logic [1:0] disp_len(input logic [7:0] o, input logic [7:0] mrm);
      logic [1:0] len;
      len = 2'd0;
      if (is_mov_acc(o)) begin
         len = 2'd2;
      end else if (needs_modrm(o)) begin
         if (mrm[7:6] == MOD_NODISP && mrm[2:0] == DIRECT_RM) begin
            len = 2'd2;
         end else if (mrm[7:6] == MOD_REGISTER) begin
            len = 2'd0;
         end else begin
            len = mrm[7:6];
         end
      end
      return len;
   endfunction

   function automatic logic [15:0] sext8(input logic [7:0] b);
      return {{8{b[7]}}, b};
   endfunction

endpackage

// ===== src/x86_16bit_instruction_decoder.sv =====
// Channel  | Dir | Width | Payload
// req      | in  | 8     | tdata[7:0] code_byte
// rsp      | out | 56    | tdata: op_group, op_variant, width_word, first_kind,
//          |     |       | first_index, second_kind, second_index, has_base,
//          |     |       | disp_present, displacement, immediate, reversed, pad
// One code byte is taken per cycle while the queue is not full; the last byte of an
// instruction writes its entry to the queue, from which the back end fills the rsp register.
// A two-entry queue parts the byte tracker from the formatter; req_tready drops
// only when the queue is full, i.e. when rsp is stalled.
// Synchronous active-high reset returns the front to the opcode phase and empties
// the queue and output register. Depends on xid_pkg, xid_front, xid_queue, xid_back.
module x86_16bit_instruction_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [7:0] code_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [2:0] op_group, [6:3] op_variant, [7] width_word, [9:8] first_kind,
   // [12:10] first_index, [14:13] second_kind, [17:15] second_index,
   // [18] has_base, [19] disp_present, [35:20] displacement, [51:36] immediate,
   // [52] reversed, [55:53] zero
   output logic [xid_pkg::RspWidth-1:0]  rsp_tdata
);

   logic               push;
   logic               queue_full;
   logic               pop;
   logic               head_valid;
   xid_pkg::entry_type push_entry;
   xid_pkg::entry_type head_entry;

   xid_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   xid_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   xid_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== src/xid_front.sv =====
// Front end: takes code bytes, tracks the byte phase and gathers one instruction.
// Pushes a finished instruction into the queue. Depends on xid_pkg.
module xid_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   output logic                push,
   output xid_pkg::entry_type  push_entry,
   input  logic                queue_full
);

   xid_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  modrm_ff, modrm_in;
   logic [15:0] disp_ff, disp_in;
   logic [15:0] imm_ff, imm_in;
   logic        accept;
   logic        unsup;
   logic        done;
   logic [7:0]  b;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;

   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      modrm_in  = modrm_ff;
      disp_in   = disp_ff;
      imm_in    = imm_ff;
      unsup     = 1'b0;
      done      = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            xid_pkg::PH_MODRM: begin
               modrm_in = b;
               if (xid_pkg::is_grp_imm(opcode_ff) && b[5:3] == xid_pkg::ALU_XOR) begin
                  unsup = 1'b1;
                  done  = 1'b1;
               end else if (xid_pkg::disp_len(opcode_ff, b) != 2'd0) begin
                  phase_in = xid_pkg::PH_DISP_LO;
               end else if (xid_pkg::imm_len(opcode_ff) != 2'd0) begin
                  phase_in = xid_pkg::PH_IMM_LO;
               end else begin
                  done = 1'b1;
               end
            end
            xid_pkg::PH_DISP_LO: begin
               disp_in = xid_pkg::sext8(b);
               if (xid_pkg::disp_len(opcode_ff, modrm_ff) == 2'd2) begin
                  phase_in = xid_pkg::PH_DISP_HI;
               end else if (xid_pkg::imm_len(opcode_ff) != 2'd0) begin
                  phase_in = xid_pkg::PH_IMM_LO;
               end else begin
                  done = 1'b1;
               end
            end
            xid_pkg::PH_DISP_HI: begin
               disp_in = {b, disp_ff[7:0]};
               if (xid_pkg::imm_len(opcode_ff) != 2'd0) begin
                  phase_in = xid_pkg::PH_IMM_LO;
               end else begin
                  done = 1'b1;
               end
            end
            xid_pkg::PH_IMM_LO: begin
               imm_in = xid_pkg::sext8(b);
               if (xid_pkg::imm_len(opcode_ff) == 2'd2) begin
                  phase_in = xid_pkg::PH_IMM_HI;
               end else begin
                  done = 1'b1;
               end
            end
            xid_pkg::PH_IMM_HI: begin
               imm_in = {b, imm_ff[7:0]};
               done   = 1'b1;
            end
            default: begin
               opcode_in = b;
               modrm_in  = 8'h00;
               disp_in   = 16'h0000;
               imm_in    = 16'h0000;
               if (!xid_pkg::supported(b)) begin
                  unsup = 1'b1;
                  done  = 1'b1;
               end else if (xid_pkg::needs_modrm(b)) begin
                  phase_in = xid_pkg::PH_MODRM;
               end else if (xid_pkg::is_mov_acc(b)) begin
                  phase_in = xid_pkg::PH_DISP_LO;
               end else begin
                  phase_in = xid_pkg::PH_IMM_LO;
               end
            end
         endcase
         if (done) begin
            phase_in = xid_pkg::PH_OPCODE;
         end
      end
   end

   assign push              = done;
   assign push_entry.unsup  = unsup;
   assign push_entry.opcode = opcode_in;
   assign push_entry.modrm  = modrm_in;
   assign push_entry.disp   = disp_in;
   assign push_entry.imm    = imm_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= xid_pkg::PH_OPCODE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff <= opcode_in;
      modrm_ff  <= modrm_in;
      disp_ff   <= disp_in;
      imm_ff    <= imm_in;
   end

endmodule

// ===== src/xid_queue.sv =====
// Short queue of gathered instructions between front and back end.
// Depends on xid_pkg.
module xid_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  xid_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output xid_pkg::entry_type  head_entry
);

   xid_pkg::entry_type mem_ff [xid_pkg::QueueDepth];
   logic [xid_pkg::PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [xid_pkg::PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [xid_pkg::CountWidth-1:0] count_ff, count_in;

   localparam logic [xid_pkg::CountWidth-1:0] DepthCount =
      xid_pkg::CountWidth'(xid_pkg::QueueDepth);
   localparam logic [xid_pkg::PtrWidth-1:0] LastPtr =
      xid_pkg::PtrWidth'(xid_pkg::QueueDepth - 1);

   assign full       = (count_ff == DepthCount);
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCount)
      else $error("queue count exceeds depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance on push");

endmodule

// ===== src/xid_back.sv =====
// Back end: formats a gathered instruction into a decoded record and holds
// it in the output register. Depends on xid_pkg.
module xid_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  xid_pkg::entry_type            head_entry,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [xid_pkg::RspWidth-1:0]  rsp_tdata
);

   typedef struct packed {
      logic [2:0]  op_group;
      logic [3:0]  op_variant;
      logic        width_word;
      logic [1:0]  first_kind;
      logic [2:0]  first_index;
      logic [1:0]  second_kind;
      logic [2:0]  second_index;
      logic        has_base;
      logic        disp_present;
      logic [15:0] displacement;
      logic [15:0] immediate;
      logic        reversed;
   } rec_type;

   function automatic rec_type decode(input xid_pkg::entry_type e);
      rec_type    r;
      logic [7:0] o;
      logic [2:0] reg_f;
      logic [1:0] md;
      logic [2:0] rm;
      logic       mem_rm;
      o      = e.opcode;
      reg_f  = e.modrm[5:3];
      md     = e.modrm[7:6];
      rm     = e.modrm[2:0];
      mem_rm = 1'b0;
      r      = '0;
      if (e.unsup) begin
         r.op_group    = xid_pkg::GRP_UNSUP;
         r.first_kind  = xid_pkg::KIND_NONE;
         r.second_kind = xid_pkg::KIND_NONE;
      end else begin
         r.width_word  = o[0];
         r.second_kind = xid_pkg::KIND_IMM;
         r.immediate   = e.imm;
         if (xid_pkg::is_alu_rm(o) || xid_pkg::is_mov_rm(o)) begin
            r.op_group     = xid_pkg::is_alu_rm(o) ? xid_pkg::GRP_ALU : xid_pkg::GRP_MOV;
            r.op_variant   = xid_pkg::is_alu_rm(o) ? {1'b0, o[5:3]} : 4'd0;
            mem_rm         = 1'b1;
            r.second_kind  = xid_pkg::KIND_REG;
            r.second_index = reg_f;
            r.immediate    = 16'h0000;
            r.reversed     = o[1];
         end else if (xid_pkg::is_alu_acc(o)) begin
            r.op_group   = xid_pkg::GRP_ALU;
            r.op_variant = {1'b0, o[5:3]};
            r.first_kind = xid_pkg::KIND_REG;
         end else if (xid_pkg::is_grp_imm(o) || xid_pkg::is_mov_imm_rm(o)) begin
            r.op_group   = xid_pkg::is_grp_imm(o) ? xid_pkg::GRP_ALU : xid_pkg::GRP_MOV;
            r.op_variant = xid_pkg::is_grp_imm(o) ? {1'b0, reg_f} : 4'd0;
            mem_rm       = 1'b1;
         end else if (xid_pkg::is_mov_imm_reg(o)) begin
            r.width_word  = o[3];
            r.first_kind  = xid_pkg::KIND_REG;
            r.first_index = o[2:0];
         end else if (xid_pkg::is_mov_acc(o)) begin
            r.first_kind   = xid_pkg::KIND_REG;
            r.second_kind  = xid_pkg::KIND_MEM;
            r.second_index = xid_pkg::DIRECT_RM;
            r.disp_present = 1'b1;
            r.displacement = e.disp;
            r.immediate    = 16'h0000;
            r.reversed     = o[1];
         end else begin
            r.op_group    = xid_pkg::is_jcc(o) ? xid_pkg::GRP_JCC : xid_pkg::GRP_LOOP;
            r.op_variant  = xid_pkg::is_jcc(o) ? o[3:0] : {2'b00, o[1:0]};
            r.width_word  = 1'b0;
            r.first_kind  = xid_pkg::KIND_IMM;
            r.second_kind = xid_pkg::KIND_NONE;
         end
         // r/m operand always lands in the first slot
         if (mem_rm) begin
            r.first_index = rm;
            if (md == xid_pkg::MOD_REGISTER) begin
               r.first_kind = xid_pkg::KIND_REG;
            end else begin
               r.first_kind   = xid_pkg::KIND_MEM;
               r.has_base     = !(md == xid_pkg::MOD_NODISP && rm == xid_pkg::DIRECT_RM);
               r.disp_present = (xid_pkg::disp_len(o, e.modrm) != 2'd0);
               r.displacement = r.disp_present ? e.disp : 16'h0000;
            end
         end
      end
      return r;
   endfunction

   logic    valid_ff, valid_in;
   rec_type rec_ff, rec_in;

   assign pop = head_valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      rec_in   = rec_ff;
      if (pop) begin
         valid_in = 1'b1;
         rec_in   = decode(head_entry);
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b000, rec_ff.reversed, rec_ff.immediate, rec_ff.displacement,
                        rec_ff.disp_present, rec_ff.has_base, rec_ff.second_index,
                        rec_ff.second_kind, rec_ff.first_index, rec_ff.first_kind,
                        rec_ff.width_word, rec_ff.op_variant, rec_ff.op_group};

endmodule
